>>> src/bpd_pkg.sv
`default_nettype none

package bpd_pkg;

  // Operation codes carried on the request channel
  typedef enum logic [2:0] {
    OP_PUSH_HEAD  = 3'd0,
    OP_PUSH_TAIL  = 3'd1,
    OP_POP_HEAD   = 3'd2,
    OP_POP_TAIL   = 3'd3,
    OP_READ_HEAD  = 3'd4,
    OP_READ_TAIL  = 3'd5,
    OP_READ_INDEX = 3'd6,
    OP_SET_SYMBOL = 3'd7
  } opcode_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  localparam int unsigned CoordW  = 8;
  localparam int unsigned SymbolW = 8;
  localparam int unsigned SlotW   = 8;
  localparam int unsigned CountW  = 9;

  // Entry store access for one operation
  typedef struct packed {
    logic xy_we;
    logic sym_we;
    logic rd_en;
  } mem_cmd_t;

  // Result information that travels beside the store read
  typedef struct packed {
    logic                do_read;
    status_e             status;
    logic [CountW-1:0]   count;
  } meta_t;

endpackage

`default_nettype wire

>>> src/bpd_req_if.sv
`default_nettype none

interface bpd_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [7:0] pos_x;
  logic [7:0] pos_y;
  logic [7:0] symbol;
  logic [7:0] slot;

  modport source (output valid, opcode, pos_x, pos_y, symbol, slot, input ready);
  modport sink   (input valid, opcode, pos_x, pos_y, symbol, slot, output ready);
endinterface

`default_nettype wire

>>> src/bpd_rsp_if.sv
`default_nettype none

interface bpd_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_x;
  logic [7:0] out_y;
  logic [7:0] out_symbol;
  logic [8:0] entry_count;
  logic [1:0] status;

  modport source (output valid, out_x, out_y, out_symbol, entry_count, status, input ready);
  modport sink   (input valid, out_x, out_y, out_symbol, entry_count, status, output ready);
endinterface

`default_nettype wire

>>> src/bpd_ram.sv
`default_nettype none

module bpd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                                          clk_i,
  input  wire logic                                          en_i,
  input  wire logic                                          we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]                              wdata_i,
  output      logic [WIDTH-1:0]                              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single port: write, or registered read
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> src/bpd_ctrl.sv
`default_nettype none

module bpd_ctrl #(
  parameter int unsigned CAPACITY = 256
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             accept_i,
  input  wire logic [2:0]                       opcode_i,
  input  wire logic [bpd_pkg::SlotW-1:0]        slot_i,
  output      bpd_pkg::mem_cmd_t                cmd_o,
  output      logic [$clog2(CAPACITY)-1:0]      addr_o,
  output      bpd_pkg::meta_t                   meta_o
);

  localparam int unsigned PtrW = $clog2(CAPACITY);
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned SumW = ((PtrW > bpd_pkg::SlotW) ? PtrW : bpd_pkg::SlotW) + 1;
  localparam logic [SumW-1:0] CapSum = SumW'(CAPACITY);
  localparam logic [CntW-1:0] CapCnt = CntW'(CAPACITY);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(CAPACITY - 1);

  logic [PtrW-1:0] head_q, head_d;
  logic [CntW-1:0] occ_q, occ_d;

  logic [SumW-1:0] lidx;
  logic [SumW-1:0] ring_sum;
  logic [SumW-1:0] ring_wrap;
  logic [PtrW-1:0] ring_addr;
  logic [PtrW-1:0] head_dec;
  logic [PtrW-1:0] head_inc;
  logic            is_full;
  logic            is_empty;
  logic            in_range;
  bpd_pkg::opcode_e op;

  assign op       = bpd_pkg::opcode_e'(opcode_i);
  assign is_full  = (occ_q == CapCnt);
  assign is_empty = (occ_q == '0);

  // Logical index from the head for this operation
  always_comb begin
    case (op)
      bpd_pkg::OP_PUSH_TAIL: lidx = SumW'(occ_q);
      bpd_pkg::OP_READ_HEAD: lidx = '0;
      bpd_pkg::OP_READ_TAIL: lidx = is_empty ? '0 : SumW'(occ_q - CntW'(1));
      default:               lidx = SumW'(slot_i);
    endcase
  end

  // Ring position: one add and one compare-subtract
  assign ring_sum  = SumW'(head_q) + lidx;
  assign ring_wrap = (ring_sum >= CapSum) ? (ring_sum - CapSum) : ring_sum;
  assign ring_addr = ring_wrap[PtrW-1:0];
  assign in_range  = (lidx < SumW'(occ_q));

  assign head_dec = (head_q == '0) ? LastPtr : (head_q - PtrW'(1));
  assign head_inc = (head_q == LastPtr) ? '0 : (head_q + PtrW'(1));

  // Operation decode
  always_comb begin
    head_d         = head_q;
    occ_d          = occ_q;
    cmd_o          = '0;
    addr_o         = ring_addr;
    meta_o.do_read = 1'b0;
    meta_o.status  = bpd_pkg::ST_OK;
    unique case (op) inside
      bpd_pkg::OP_PUSH_HEAD: begin
        addr_o = head_dec;
        if (is_full) begin
          meta_o.status = bpd_pkg::ST_FULL;
        end else begin
          head_d       = head_dec;
          occ_d        = occ_q + CntW'(1);
          cmd_o.xy_we  = 1'b1;
          cmd_o.sym_we = 1'b1;
        end
      end
      bpd_pkg::OP_PUSH_TAIL: begin
        if (is_full) begin
          meta_o.status = bpd_pkg::ST_FULL;
        end else begin
          occ_d        = occ_q + CntW'(1);
          cmd_o.xy_we  = 1'b1;
          cmd_o.sym_we = 1'b1;
        end
      end
      bpd_pkg::OP_POP_HEAD: begin
        if (is_empty) begin
          meta_o.status = bpd_pkg::ST_EMPTY;
        end else begin
          head_d = head_inc;
          occ_d  = occ_q - CntW'(1);
        end
      end
      bpd_pkg::OP_POP_TAIL: begin
        if (is_empty) begin
          meta_o.status = bpd_pkg::ST_EMPTY;
        end else begin
          occ_d = occ_q - CntW'(1);
        end
      end
      bpd_pkg::OP_READ_HEAD, bpd_pkg::OP_READ_TAIL, bpd_pkg::OP_READ_INDEX: begin
        if (in_range) begin
          cmd_o.rd_en    = 1'b1;
          meta_o.do_read = 1'b1;
        end else begin
          meta_o.status = bpd_pkg::ST_EMPTY;
        end
      end
      bpd_pkg::OP_SET_SYMBOL: begin
        if (in_range) begin
          cmd_o.sym_we = 1'b1;
        end else begin
          meta_o.status = bpd_pkg::ST_EMPTY;
        end
      end
      default: begin
        meta_o.status = bpd_pkg::ST_OK;
      end
    endcase
    meta_o.count = bpd_pkg::CountW'(occ_d);
  end

  // Head pointer and occupancy, updated per transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      occ_q  <= '0;
    end else if (accept_i) begin
      head_q <= head_d;
      occ_q  <= occ_d;
    end
  end

`ifndef SYNTH
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CapCnt)
    else $error("occupancy above capacity");

  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= LastPtr)
    else $error("head pointer outside ring");

  a_no_store_write_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_en |-> !cmd_o.xy_we && !cmd_o.sym_we)
    else $error("store read and write in one operation");
`endif

endmodule

`default_nettype wire

>>> src/bounded_position_deque.sv
// Bounded double-ended list of (x, y, symbol) entries kept in a ring buffer.
//
// Channels: req_i carries one operation per transfer (opcode, pos_x, pos_y,
// symbol, slot); rsp_o returns exactly one result per operation (out_x,
// out_y, out_symbol, entry_count, status), in order. Both use valid/ready;
// a transfer happens when both are high at a rising edge of clk_i.
//
// Pipeline: the transfer edge itself performs the operation's store access,
// if any (registered read), and loads the read stage; the read stage then
// passes the read data and result information into the result register,
// which drives rsp_o.
// Throughput: one operation per cycle, sustained while rsp_o.ready is high,
// limited by at most one access per operation to each single-port store.
//
// Stall: when rsp_o.ready is low the result register holds, the operation
// in the read stage waits behind it, and req_i.ready drops once both are
// full. No result is lost or repeated.
//
// Reset (rst_ni low, asynchronous): the list becomes empty and the head
// pointer returns to zero. The entry store is not cleared; only entries
// below the count are ever read.
`default_nettype none

module bounded_position_deque #(
  parameter int unsigned CAPACITY = 256
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bpd_req_if.sink    req_i,
  bpd_rsp_if.source  rsp_o
);

  localparam int unsigned PtrW = $clog2(CAPACITY);
  localparam int unsigned XyW  = 2 * bpd_pkg::CoordW;

  bpd_pkg::mem_cmd_t cmd;
  bpd_pkg::meta_t    meta;
  logic [PtrW-1:0]   addr;
  logic              accept;
  logic              s1_adv;

  logic              s1_valid_q, s1_valid_d;
  bpd_pkg::meta_t    s1_meta_q;

  logic [XyW-1:0]                xy_rdata;
  logic [bpd_pkg::SymbolW-1:0]   sym_rdata;

  logic                          out_valid_q, out_valid_d;
  logic [bpd_pkg::CoordW-1:0]    out_x_q;
  logic [bpd_pkg::CoordW-1:0]    out_y_q;
  logic [bpd_pkg::SymbolW-1:0]   out_sym_q;
  logic [bpd_pkg::CountW-1:0]    out_count_q;
  logic [1:0]                    out_status_q;

  // Handshake: the read stage moves on when the result register is empty or its result is taken
  assign s1_adv      = !out_valid_q || rsp_o.ready;
  assign req_i.ready = !s1_valid_q || s1_adv;
  assign accept      = req_i.valid && req_i.ready;

  bpd_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .opcode_i (req_i.opcode),
    .slot_i   (req_i.slot),
    .cmd_o    (cmd),
    .addr_o   (addr),
    .meta_o   (meta)
  );

  // Coordinate store
  bpd_ram #(
    .WIDTH (XyW),
    .DEPTH (CAPACITY)
  ) u_xy_ram (
    .clk_i   (clk_i),
    .en_i    (accept && (cmd.xy_we || cmd.rd_en)),
    .we_i    (cmd.xy_we),
    .addr_i  (addr),
    .wdata_i ({req_i.pos_x, req_i.pos_y}),
    .rdata_o (xy_rdata)
  );

  // Symbol store, written apart so a symbol update leaves x and y alone
  bpd_ram #(
    .WIDTH (bpd_pkg::SymbolW),
    .DEPTH (CAPACITY)
  ) u_sym_ram (
    .clk_i   (clk_i),
    .en_i    (accept && (cmd.sym_we || cmd.rd_en)),
    .we_i    (cmd.sym_we),
    .addr_i  (addr),
    .wdata_i (req_i.symbol),
    .rdata_o (sym_rdata)
  );

  // Read stage and result register valid flags
  always_comb begin
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = s1_valid_q;
      s1_valid_d  = 1'b0;
    end
    if (accept) begin
      s1_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_meta_q <= meta;
    end
    if (s1_adv && s1_valid_q) begin
      out_count_q  <= s1_meta_q.count;
      out_status_q <= s1_meta_q.status;
      if (s1_meta_q.do_read) begin
        out_x_q   <= xy_rdata[XyW-1:bpd_pkg::CoordW];
        out_y_q   <= xy_rdata[bpd_pkg::CoordW-1:0];
        out_sym_q <= sym_rdata;
      end else begin
        out_x_q   <= '0;
        out_y_q   <= '0;
        out_sym_q <= '0;
      end
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.out_x       = out_x_q;
  assign rsp_o.out_y       = out_y_q;
  assign rsp_o.out_symbol  = out_sym_q;
  assign rsp_o.entry_count = out_count_q;
  assign rsp_o.status      = out_status_q;

`ifndef SYNTH
  a_accept_fills_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("transferred operation missing from read stage");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |-> !req_i.ready)
    else $error("request taken while read stage is blocked");

  a_fail_zero_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q != bpd_pkg::ST_OK))
      |-> (out_x_q == '0) && (out_y_q == '0) && (out_sym_q == '0))
    else $error("failed operation returned entry data");
`endif

endmodule

`default_nettype wire
